// File: sv/integer_stack_machine_macros.svh
// assertion macros for the integer stack machine
// expects clk and rst_n in the scope where a macro is used
`ifndef INTEGER_STACK_MACHINE_MACROS_SVH
`define INTEGER_STACK_MACHINE_MACROS_SVH

// property that holds at every edge out of reset
`define ISM_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent checked in the same cycle
`define ISM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define ISM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ism_pkg.sv
// shared types and constants for the integer stack machine
// no dependencies
package ism_pkg;

  localparam int DATA_W  = 64;
  localparam int HALF_W  = DATA_W / 2;
  localparam int FUNC_W  = 3;
  localparam int DEPTH_W = 5;
  localparam int STAT_W  = 2;

  localparam logic [FUNC_W-1:0] OP_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] OP_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_DIV  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER    = 2'd2;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPND,
    S_MUL,
    S_DIV,
    S_WB,
    S_DONE
  } state_t;

endpackage

// File: sv/ism_in_if.sv
// instruction channel: valid/ready handshake with opcode and immediate
// depends on ism_pkg
interface ism_in_if import ism_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] immediate;

  modport source (output valid, output func, output immediate, input ready);
  modport sink (input valid, input func, input immediate, output ready);
endinterface

// File: sv/ism_out_if.sv
// result channel: valid/ready handshake with top of stack, depth and status
// depends on ism_pkg
interface ism_out_if import ism_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output top_value, output depth, output status, input ready);
  modport sink (input valid, input top_value, input depth, input status, output ready);
endinterface

// File: sv/integer_stack_machine.sv
// integer stack machine: one instruction per transaction, one result per instruction.
// push, no-op and errors go from decode straight to done; multiply uses three 32x32
// partial products and divide makes one quotient bit per cycle; the next instruction
// is accepted once the result is registered for output, not before.
// sync active-low reset empties the stack; entries live in a ram with no reset.
module integer_stack_machine import ism_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  ism_in_if.sink     in_ch,
  ism_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

  state_t             state_r, state_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [DATA_W-1:0]  imm_r, imm_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DATA_W-1:0]  top_r, top_nxt;
  logic [DATA_W-1:0]  res_r, res_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_top_r, out_top_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  cnt_m2;
  logic              is_push, is_arith, underflow, div_zero, out_free;
  logic              mul_start, mul_done, div_start, div_done;
  logic [DATA_W-1:0] mul_p, div_q;

  // the top of stack is mirrored in top_r, so an operation reads only its left operand
  ism_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ism_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (ram_rdata),
    .b     (top_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  ism_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (ram_rdata),
    .b     (top_r),
    .done  (div_done),
    .q     (div_q)
  );

  assign cnt_m2    = count_r - CNT_TWO;
  assign is_push   = (func_r == OP_PUSH);
  assign is_arith  = (func_r == OP_ADD) || (func_r == OP_SUB) ||
                     (func_r == OP_MUL) || (func_r == OP_DIV);
  assign underflow = (count_r < CNT_TWO);
  assign div_zero  = (func_r == OP_DIV) && (top_r == '0);
  assign out_free  = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (is_arith && !underflow && !div_zero) state_nxt = S_OPND;
        else state_nxt = S_DONE;
      end
      S_OPND: begin
        case (func_r)
          OP_MUL:  state_nxt = S_MUL;
          OP_DIV:  state_nxt = S_DIV;
          default: state_nxt = S_WB;
        endcase
      end
      S_MUL: begin
        if (mul_done) state_nxt = S_WB;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_WB;
      end
      S_WB: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = imm_r;
    ram_re         = 1'b0;
    ram_raddr      = cnt_m2[AW-1:0];
    mul_start      = 1'b0;
    div_start      = 1'b0;
    func_nxt       = func_r;
    imm_nxt        = imm_r;
    count_nxt      = count_r;
    top_nxt        = top_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        func_nxt   = in_ch.func;
        imm_nxt    = in_ch.immediate;
        status_nxt = ST_OK;
      end
      S_DECODE: begin
        if (is_push) begin
          if (count_r == DEPTH_MAX) begin
            status_nxt = ST_OVER;
          end else begin
            ram_we    = 1'b1;
            top_nxt   = imm_r;
            count_nxt = count_r + 1'b1;
          end
        end else if (is_arith) begin
          if (underflow) status_nxt = ST_UNDER;
          else if (div_zero) status_nxt = ST_DIVZERO;
          else ram_re = 1'b1;
        end
      end
      S_OPND: begin
        case (func_r)
          OP_ADD:  res_nxt = ram_rdata + top_r;
          OP_SUB:  res_nxt = ram_rdata - top_r;
          OP_MUL:  mul_start = 1'b1;
          OP_DIV:  div_start = 1'b1;
          default: res_nxt = res_r;
        endcase
      end
      S_MUL: begin
        if (mul_done) res_nxt = mul_p;
      end
      S_DIV: begin
        if (div_done) res_nxt = div_q;
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m2[AW-1:0];
        ram_wdata = res_r;
        top_nxt   = res_r;
        count_nxt = count_r - 1'b1;
      end
      S_DONE: begin
        // result parks here while the previous transaction is still unclaimed
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_top_nxt    = (count_r == '0) ? '0 : top_r;
          out_depth_nxt  = DEPTH_W'(count_r);
          out_status_nxt = status_r;
        end
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    imm_r        <= imm_nxt;
    top_r        <= top_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.top_value = out_top_r;
  assign out_ch.depth     = out_depth_r;
  assign out_ch.status    = out_status_r;

`include "integer_stack_machine_macros.svh"

  `ISM_ASSERT_ALWAYS(a_count_bound, count_r <= DEPTH_MAX, "stack count beyond capacity")
  `ISM_ASSERT_NEXT(a_wb_pops, state_r == S_WB, count_r == $past(count_r) - 1'b1, "write-back did not pop")
  `ISM_ASSERT_SAME(a_over_full, state_r == S_DONE && status_r == ST_OVER, count_r == DEPTH_MAX, "overflow on a stack that is not full")
  `ISM_ASSERT_NEXT(a_push_top, state_r == S_DECODE && is_push && count_r != DEPTH_MAX, top_r == $past(imm_r), "push did not update the top")

endmodule

// File: sv/ism_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ism_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/ism_mul.sv
// 64-bit wrapping multiplier built from three 32x32 partial products
// depends on ism_pkg
module ism_mul import ism_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic              done,
  output logic [DATA_W-1:0] p
);

  logic              busy_r, busy_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [HALF_W-1:0] mx, my;
  logic [DATA_W-1:0] prod_shift;

  // low x low, then the two cross terms; high x high falls outside 64 bits
  always_comb begin
    case (step_r)
      2'd0:    begin mx = a_r[HALF_W-1:0];      my = b_r[HALF_W-1:0]; end
      2'd1:    begin mx = a_r[DATA_W-1:HALF_W]; my = b_r[HALF_W-1:0]; end
      default: begin mx = a_r[HALF_W-1:0];      my = b_r[DATA_W-1:HALF_W]; end
    endcase
  end

  assign prod_shift = {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      a_nxt    = a;
      b_nxt    = b;
    end else if (busy_r) begin
      prod_nxt = DATA_W'(mx) * DATA_W'(my);
      step_nxt = step_r + 2'd1;
      case (step_r)
        2'd0:    acc_nxt = acc_r;
        2'd1:    acc_nxt = prod_r;
        2'd2:    acc_nxt = acc_r + prod_shift;
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign done = busy_r && (step_r == 2'd3);
  assign p    = acc_r + prod_shift;

endmodule

// File: sv/ism_div.sv
// signed 64-bit divider, radix-2 restoring on magnitudes, truncates toward zero
// depends on ism_pkg
module ism_div import ism_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic              done,
  output logic [DATA_W-1:0] q
);

  localparam int ITER_W = $clog2(DATA_W + 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W);

  logic              busy_r, busy_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    iter_nxt = iter_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      neg_nxt  = a[DATA_W-1] ^ b[DATA_W-1];
      quo_nxt  = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
      den_nxt  = b[DATA_W-1] ? (DATA_W'(0) - b) : b;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (iter_r == ITER_LAST) begin
        busy_nxt = 1'b0;
      end else begin
        iter_nxt = iter_r + 1'b1;
        // diff top bit set means the trial subtraction went negative
        if (diff[DATA_W]) begin
          rem_nxt = shifted[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end else begin
          rem_nxt = diff[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      iter_r <= iter_nxt;
    end
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = busy_r && (iter_r == ITER_LAST);
  assign q    = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for integer_stack_machine: directed and random instruction streams
// with a scoreboard class that predicts top value, depth and status per instruction
// depends on ism_pkg, ism_in_if, ism_out_if and the integer_stack_machine rtl
module tb_top import ism_pkg::*; ();
  localparam int STACK_CAP = 16;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    logic [STAT_W-1:0]        status;
  } stack_result_t;

  class stack_scoreboard;
    logic signed [DATA_W-1:0] slots[];
    int unsigned              cap;
    int unsigned              count;
    stack_result_t            pending[$];
    int unsigned              failures;
    int unsigned              seen;

    function new(int unsigned depth);
      cap      = depth;
      slots    = new[depth];
      count    = 0;
      failures = 0;
      seen     = 0;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    // runs one instruction on the shadow stack and queues the result it must give
    function void note_instr(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] v);
      logic signed [DATA_W-1:0] lhs;
      logic signed [DATA_W-1:0] rhs;
      logic signed [DATA_W-1:0] res;
      logic [DATA_W-1:0]        mag_l;
      logic [DATA_W-1:0]        mag_r;
      logic [DATA_W-1:0]        quo;
      logic [STAT_W-1:0]        st;
      stack_result_t            rec;
      st  = ST_OK;
      res = '0;
      case (f)
        OP_PUSH: begin
          if (count >= cap) st = ST_OVER;
          else begin
            slots[count] = v;
            count++;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (count < 2) st = ST_UNDER;
          else begin
            rhs = slots[count-1];
            lhs = slots[count-2];
            case (f)
              OP_ADD: res = lhs + rhs;
              OP_SUB: res = lhs - rhs;
              OP_MUL: res = lhs * rhs;
              default: begin
                if (rhs == '0) st = ST_DIVZERO;
                else begin
                  // divide magnitudes, then fix the sign: truncates toward zero
                  mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                  mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                  quo   = mag_l / mag_r;
                  res   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
                end
              end
            endcase
            if (st == ST_OK) begin
              slots[count-2] = res;
              count--;
            end
          end
        end
        default: ; // unused codes leave everything alone
      endcase
      rec.top_value = (count > 0) ? slots[count-1] : '0;
      rec.depth     = DEPTH_W'(count);
      rec.status    = st;
      pending.push_back(rec);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] top, logic [DEPTH_W-1:0] d,
                               logic [STAT_W-1:0] s);
      stack_result_t rec;
      seen++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", seen));
      end else begin
        rec = pending.pop_front();
        if (rec.top_value !== top || rec.depth !== d || rec.status !== s)
          report($sformatf("result %0d: top exp %0d got %0d, depth exp %0d got %0d, status exp %0d got %0d",
                           seen, rec.top_value, top, rec.depth, d, rec.status, s));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ism_in_if  in_ch();
  ism_out_if out_ch();

  integer_stack_machine #(.STACK_DEPTH(STACK_CAP)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stack_scoreboard sb;

  bit          in_quiet  = 1'b0;
  bit          out_quiet = 1'b0;
  int unsigned out_hold  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_operand();
    logic signed [DATA_W-1:0] v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      v = $urandom_range(0, 16);
      v = v - 8;
    end else if (r < 40) begin
      case ($urandom_range(0, 4))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = '1;
        3:       v = '0;
        default: v = 1;
      endcase
    end else if (r < 55) begin
      v = {$urandom, $urandom} >> $urandom_range(0, DATA_W-1);
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = {$urandom, $urandom};
    end
    return v;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(bit growing);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return FUNC_W'($urandom_range(5, 7));
    if (r < (growing ? 80 : 25)) return OP_PUSH;
    case ($urandom_range(0, 3))
      0:       return OP_ADD;
      1:       return OP_SUB;
      2:       return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_instr(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
    int unsigned gap;
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.immediate <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_instr(f, v);
    @(negedge clk);
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.func      <= FUNC_W'($urandom);
      in_ch.immediate <= {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: stall for a while after each transaction
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.top_value, out_ch.depth, out_ch.status);
      out_hold = pick_gap(out_quiet);
    end
  end

  initial begin
    #100_000_000;
    $display("integer_stack_machine verification failed");
    $finish;
  end

  initial begin
    int unsigned left_in_mode;
    bit          growing;
    sb              = new(STACK_CAP);
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = OP_PUSH;
    in_ch.immediate = '0;
    out_ch.ready    = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: underflow on empty and on one value, wrapping divide, divide by zero
    send_instr(OP_ADD, 64'sd5);
    send_instr(OP_PUSH, VAL_MIN);
    send_instr(OP_DIV, VAL_MAX);
    send_instr(OP_PUSH, -64'sd1);
    send_instr(OP_DIV, '0);
    send_instr(OP_PUSH, VAL_MAX);
    send_instr(OP_ADD, '1);
    send_instr(OP_PUSH, '0);
    send_instr(OP_DIV, 64'sd3);
    send_instr(FUNC_W'(5), VAL_MIN);
    send_instr(FUNC_W'(7), VAL_MAX);
    send_instr(OP_SUB, '0);
    // fill the stack, then push once more for the overflow case
    for (int i = 1; i < STACK_CAP; i++) send_instr(OP_PUSH, (i == 1) ? VAL_MAX : i - 9);
    send_instr(OP_PUSH, 64'sd99);
    send_instr(OP_MUL, '1);
    drain_results();

    // random: alternate growing and shrinking stretches so depth sweeps the full range
    growing      = 1'b1;
    left_in_mode = 0;
    for (int n = 0; n < 1700; n++) begin
      if (left_in_mode == 0) begin
        growing      = !growing;
        left_in_mode = $urandom_range(8, 40);
        in_quiet     = ($urandom_range(0, 3) == 0);
        out_quiet    = ($urandom_range(0, 3) == 0);
      end
      left_in_mode--;
      if ($urandom_range(0, 299) == 0) drain_results();
      send_instr(pick_func(growing), pick_operand());
    end

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.failures == 0) begin
      $display("integer_stack_machine verification clean");
    end else begin
      $display("integer_stack_machine verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/ism_pkg.sv
sv/ism_in_if.sv
sv/ism_out_if.sv
sv/ism_ram.sv
sv/ism_mul.sv
sv/ism_div.sv
sv/integer_stack_machine.sv
bench/tb_top.sv
